// ===== rtl/core/midi_note_frequency_converter_unit_macros.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef MIDI_NOTE_FREQUENCY_CONVERTER_UNIT_MACROS_SVH
`define MIDI_NOTE_FREQUENCY_CONVERTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define MNFC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define MNFC_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define MNFC_ASSERT_IMP(label, clk, rst_n, a, b)
`define MNFC_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/core/mnfc_pkg.sv =====
package mnfc_pkg;

    // Fixed-point formats.
    localparam int FREQ_FRAC_BITS = 16;
    localparam int EXP_BITS       = 24;

    // Register map.
    localparam logic REG_ROOT  = 1'b0;
    localparam logic REG_STEPS = 1'b1;

    // Register reset values and limits.
    localparam logic [31:0] ROOT_RESET  = 32'(440) << FREQ_FRAC_BITS;
    localparam logic [7:0]  STEPS_RESET = 8'd12;
    localparam logic [7:0]  STEPS_MIN   = 8'd5;

    // Commands.
    localparam logic CMD_N2F = 1'b0;
    localparam logic CMD_F2N = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_NOTE  = 2'd1,
        ST_ZERO_FREQ = 2'd2,
        ST_SAT       = 2'd3
    } t_status;

    // Note limits and rounding bias (69 plus one half, 24 fraction bits).
    localparam logic [7:0]         NOTE_MAX = 8'd127;
    localparam logic [11:0]        NOTE_REF = 12'd69;
    localparam logic signed [39:0] X_BIAS   = (40'sd69 <<< EXP_BITS) + (40'sd1 <<< (EXP_BITS - 1));

    // Pipeline layout.
    localparam int DIV_BITS      = 36;
    localparam int DIV_PER_STG   = 4;
    localparam int NUM_DIV_STG   = DIV_BITS / DIV_PER_STG;
    localparam int STG_NORM      = 1;
    localparam int STG_DIV0      = 2;
    localparam int STG_RND0      = STG_DIV0 + NUM_DIV_STG;
    localparam int STG_MUL       = STG_RND0 + EXP_BITS;
    localparam int STG_SHIFT     = STG_MUL + 1;
    localparam int NUM_STG       = STG_SHIFT + 1;

    // Exponent shift base: 30 fraction bits of the Q1.30 mantissa plus the 14-step offset.
    localparam logic [5:0] SHIFT_BASE = 6'd44;

    // Data carried by every pipeline stage.
    typedef struct packed {
        logic        cmd;
        logic        bad_note;
        logic        zero_freq;
        logic [31:0] root;
        logic [7:0]  steps;
        logic [35:0] dvd;
        logic [7:0]  rem;
        logic [35:0] quo;
        logic [30:0] acc;
        logic [4:0]  topf;
        logic [4:0]  topr;
        logic [31:0] mf;
        logic [31:0] mr;
        logic [23:0] lff;
        logic [23:0] lfr;
        logic [62:0] prod;
        logic [29:0] dlog;
        logic [43:0] rsh;
        logic [15:0] nn;
    } t_stg;

    typedef logic [EXP_BITS-1:0][30:0] t_fac_tab;

    // Truncating integer square root, used only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Factors 2^(2^-(i+1)) in Q1.30 from repeated square roots of 2.0.
    function automatic t_fac_tab build_factors();
        t_fac_tab    t;
        logic [63:0] f;
        f = 64'd1 << 31;
        for (int i = 0; i < EXP_BITS; i++) begin
            f    = isqrt64(f << 30);
            t[i] = f[30:0];
        end
        return t;
    endfunction

    localparam t_fac_tab EXP_FACTOR = build_factors();

endpackage

// ===== rtl/core/midi_note_frequency_converter_unit.sv =====
// Note/frequency converter, fully pipelined: one transaction per cycle in and out
// while i_stall does not hold the output (o_stall then holds the input). Stages: one
// input stage, one normalize stage, 9 divider stages (4 quotient bits each), 24 rounds
// of exp2 and log2 multiplies, one product stage, one shift stage and the output register.
// Synchronous active-low reset clears all valid bits and loads the reset register values.
`include "midi_note_frequency_converter_unit_macros.svh"

module midi_note_frequency_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_note_in,
    input  logic [31:0] i_frequency_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_frequency_out,
    output logic [6:0]  o_note_out,
    output logic [1:0]  o_status
);
    import mnfc_pkg::*;

    logic [31:0]  r_root;
    logic [7:0]   r_steps;
    logic         r_v [NUM_STG];
    t_stg         r_stg [NUM_STG];
    t_stg         n_stg [NUM_STG];
    logic [NUM_STG:0] en;
    logic         r_ov;
    logic [31:0]  r_of;
    logic [6:0]   r_on;
    t_status      r_ost;
    logic [31:0]  n_of;
    logic [6:0]   n_on;
    t_status      n_ost;

    // Index of the highest set bit, zero for a zero word.
    function automatic logic [4:0] top_bit(input logic [31:0] x);
        logic [4:0] t;
        t = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) t = 5'(i);
        end
        return t;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= ROOT_RESET;
            r_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROOT:  r_root  <= i_cfg_wdata;
                REG_STEPS: r_steps <= i_cfg_wdata[7:0];
                default:   r_root  <= r_root;
            endcase
        end
    end

    // Stall chain: a stage moves when it is empty or the next stage moves.
    always_comb begin
        en[NUM_STG] = !r_ov || !i_stall;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_stall = !en[0];

    // Stage logic.
    always_comb begin
        t_stg              p;
        logic [8:0]        t9;
        logic [61:0]       pe;
        logic [63:0]       sq;
        logic [32:0]       tq;
        logic [5:0]        shamt;
        logic [62:0]       rs;
        logic signed [38:0] pr;
        logic signed [39:0] x;
        logic [11:0]       num;
        logic [7:0]        st;

        // Input stage: clamp registers, build the dividend, find top bits.
        st              = (r_steps < STEPS_MIN) ? STEPS_MIN : r_steps;
        num             = {4'd0, i_note_in} + ({4'd0, st} << 4) - ({4'd0, st} << 1) - NOTE_REF;
        p               = '0;
        p.cmd           = i_cmd;
        p.bad_note      = (i_note_in > NOTE_MAX);
        p.zero_freq     = (i_frequency_in == 32'd0);
        p.root          = (r_root == 32'd0) ? 32'd1 : r_root;
        p.steps         = st;
        p.dvd           = {num, 24'd0};
        p.acc           = 31'(1) << 30;
        p.mf            = i_frequency_in;
        p.mr            = p.root;
        p.topf          = top_bit(i_frequency_in);
        p.topr          = top_bit(p.root);
        n_stg[0]        = p;
        t9 = '0; pe = '0; sq = '0; tq = '0; shamt = '0; rs = '0; pr = '0; x = '0;

        for (int k = 1; k < NUM_STG; k++) begin
            p = r_stg[k-1];
            if (k == STG_NORM) begin
                // Normalize both log operands to Q1.31.
                p.mf = p.mf << (~p.topf);
                p.mr = p.mr << (~p.topr);
            end else if (k >= STG_DIV0 && k < STG_RND0) begin
                // Restoring division, four quotient bits.
                for (int b = 0; b < DIV_PER_STG; b++) begin
                    t9    = {p.rem, p.dvd[35]};
                    p.dvd = p.dvd << 1;
                    if (t9 >= {1'b0, p.steps}) begin
                        p.rem = 8'(t9 - {1'b0, p.steps});
                        p.quo = {p.quo[34:0], 1'b1};
                    end else begin
                        p.rem = t9[7:0];
                        p.quo = {p.quo[34:0], 1'b0};
                    end
                end
            end else if (k >= STG_RND0 && k < STG_MUL) begin
                // One exp2 factor and one squaring round for each log2.
                if (p.quo[EXP_BITS - 1 - (k - STG_RND0)]) begin
                    pe    = p.acc * EXP_FACTOR[k - STG_RND0];
                    p.acc = pe[60:30];
                end
                sq = p.mf * p.mf;
                tq = sq[63:31];
                p.lff = {p.lff[22:0], tq[32]};
                p.mf  = tq[32] ? tq[32:1] : tq[31:0];
                sq = p.mr * p.mr;
                tq = sq[63:31];
                p.lfr = {p.lfr[22:0], tq[32]};
                p.mr  = tq[32] ? tq[32:1] : tq[31:0];
            end else if (k == STG_MUL) begin
                // Scale by the root; difference of the two logarithms.
                p.prod = p.root * p.acc;
                p.dlog = {1'b0, p.topf, p.lff} - {1'b0, p.topr, p.lfr};
            end else begin
                // Apply the integer exponent; scale the log difference to notes.
                shamt = SHIFT_BASE - {1'b0, p.quo[28:24]};
                rs    = p.prod >> shamt;
                p.rsh = rs[43:0];
                pr    = $signed(p.dlog) * $signed({1'b0, p.steps});
                x     = {pr[38], pr} + X_BIAS;
                p.nn  = x[39:24];
            end
            n_stg[k] = p;
        end
    end

    // Final saturation, clamping and status.
    always_comb begin
        t_stg q;
        q     = r_stg[NUM_STG-1];
        n_of  = '0;
        n_on  = '0;
        n_ost = ST_OK;
        if (q.cmd == CMD_N2F) begin
            if (q.bad_note) begin
                n_ost = ST_BAD_NOTE;
            end else if (|q.rsh[43:32]) begin
                n_of  = '1;
                n_ost = ST_SAT;
            end else begin
                n_of  = q.rsh[31:0];
            end
        end else begin
            if (q.zero_freq) begin
                n_ost = ST_ZERO_FREQ;
            end else if (q.nn[15]) begin
                n_ost = ST_SAT;
            end else if (q.nn > 16'(NOTE_MAX)) begin
                n_on  = NOTE_MAX[6:0];
                n_ost = ST_SAT;
            end else begin
                n_on  = q.nn[6:0];
            end
        end
    end

    // Pipeline registers; only valid bits are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STG; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en[0]) begin
                r_v[0]   <= i_valid;
                r_stg[0] <= n_stg[0];
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (en[k]) begin
                    r_v[k]   <= r_v[k-1];
                    r_stg[k] <= n_stg[k];
                end
            end
            if (en[NUM_STG]) begin
                r_ov  <= r_v[NUM_STG-1];
                r_of  <= n_of;
                r_on  <= n_on;
                r_ost <= n_ost;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_frequency_out = r_of;
    assign o_note_out      = r_on;
    assign o_status        = r_ost;

    // A held item in the input stage is not dropped.
    `MNFC_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_v[0] && !en[0], r_v[0])
    // The last stage moves into the output register when the output frees up.
    `MNFC_ASSERT_NXT(a_out_load, i_clk, i_rst_n, r_v[NUM_STG-1] && en[NUM_STG], r_ov)
    // An invalid note gives no frequency and no note.
    `MNFC_ASSERT_IMP(a_bad_note, i_clk, i_rst_n, o_valid && o_status == ST_BAD_NOTE, o_frequency_out == 32'd0 && o_note_out == 7'd0)
    // Only one of the two results is ever nonzero.
    `MNFC_ASSERT_IMP(a_one_result, i_clk, i_rst_n, o_valid && o_frequency_out != 32'd0, o_note_out == 7'd0)

endmodule
